@@ rtl/mda_pkg.sv @@
// shared constants and types for the multidim array address generator
package mda_pkg;

  // default table depth
  localparam int MAX_DIMS_DEFAULT = 16;

  // input item operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_INDEX = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS     = 2'd2;

  // field widths
  localparam int WORD_W  = 32;
  localparam int ESIZE_W = 31;
  localparam int NDIMS_W = 5;
  localparam int DSEL_W  = 4;

  // one dimension's entry in the bounds table
  typedef struct packed {
    logic [WORD_W-1:0] lower;
    logic [WORD_W-1:0] extent;
  } dim_entry_t;

endpackage

@@ rtl/mda_ram.sv @@
// generic single-write, single-read ram with registered read data
module mda_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/multidim_array_address.sv @@
// top level of the row-major multidim array address generator
//
// Computes base_address + offset * element_size for a row-major array with
// per-dimension lower and upper bounds. A load item (op 0) writes one
// dimension's lower bound and extent into the bounds table and is taken
// with the block staying ready. Index items (op 1) come in dimension
// order; each folds into the offset as offset * extent + (index - lower).
// A non-final index passes through a registered table read, the shared
// 32x32 multiplier and an add, in that order. For the final index of a
// sequence the multiplier is then used a second time for the element size
// and an add for the base, and the result waits while the previous result
// still sits stalled in the output register. All arithmetic wraps at 32 bits
// and indexes are not checked against their bounds. Reading a dimension that
// was never loaded gives an undefined address.
module multidim_array_address
  import mda_pkg::*;
#(
  parameter int MAX_DIMS = MAX_DIMS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [DSEL_W-1:0]     dim_select,
  input  logic signed [WORD_W-1:0] lower_bound,
  input  logic signed [WORD_W-1:0] upper_bound,
  input  logic signed [WORD_W-1:0] index_value,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [WORD_W-1:0] address,
  // configuration write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW = ($clog2(MAX_DIMS + 1) > NDIMS_W) ? $clog2(MAX_DIMS + 1) : NDIMS_W;
  localparam int EW = $bits(dim_entry_t);

  // sequencer state codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]          state;
  logic [WORD_W-1:0]   base_address;
  logic [ESIZE_W-1:0]  element_size;
  logic [NDIMS_W-1:0]  num_dims;
  logic [WORD_W-1:0]   acc;
  logic [CW-1:0]       cnt;
  logic                last_dim;
  logic [WORD_W-1:0]   idx;
  logic [WORD_W-1:0]   prod;
  logic [WORD_W-1:0]   diff;

  logic                in_xfer;
  logic                out_xfer;
  logic [CW-1:0]       nd_ext;
  logic [CW-1:0]       nd_clamp;
  logic [CW-1:0]       last_k;
  logic [CW-1:0]       k_eff;
  logic                table_we;
  dim_entry_t          wr_entry;
  dim_entry_t          rd_entry;
  logic [EW-1:0]       rd_bits;
  logic [WORD_W-1:0]   mul_a;
  logic [WORD_W-1:0]   mul_b;
  logic [WORD_W-1:0]   mul_p;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // dimension count clamped to 1..MAX_DIMS, and the current dimension
  assign nd_ext   = CW'(num_dims);
  assign nd_clamp = (nd_ext == '0) ? CW'(1) :
                    ((nd_ext > CW'(MAX_DIMS)) ? CW'(MAX_DIMS) : nd_ext);
  assign last_k   = nd_clamp - CW'(1);
  assign k_eff    = (cnt >= last_k) ? last_k : cnt;

  // bounds table write on a load transfer
  assign table_we        = in_xfer && (op == OP_LOAD) &&
                           (32'(dim_select) < 32'(MAX_DIMS));
  assign wr_entry.lower  = lower_bound;
  assign wr_entry.extent = upper_bound - lower_bound + WORD_W'(1);
  assign rd_entry        = dim_entry_t'(rd_bits);

  mda_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_DIMS)
  ) u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (AW'(dim_select)),
    .wdata (wr_entry),
    .raddr (k_eff[AW-1:0]),
    .rdata (rd_bits)
  );

  // shared multiplier: extent product, then element size product
  assign mul_a = acc;
  assign mul_b = (state == S_MUL) ? rd_entry.extent : {1'b0, element_size};
  assign mul_p = mul_a * mul_b;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      element_size <= ESIZE_W'(1);
      num_dims     <= NDIMS_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_ADDRESS: base_address <= cfg_data[WORD_W-1:0];
        REG_ELEMENT_SIZE: element_size <= cfg_data[ESIZE_W-1:0];
        REG_NUM_DIMS:     num_dims     <= cfg_data[NDIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc   <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer && (op == OP_INDEX)) begin
            cnt   <= k_eff;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= prod + diff;
          if (last_dim) begin
            state <= S_SCALE;
          end else begin
            cnt   <= cnt + CW'(1);
            state <= S_IDLE;
          end
        end
        S_SCALE: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            acc   <= '0;
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer && (op == OP_INDEX)) begin
      idx      <= index_value;
      last_dim <= (cnt >= last_k);
    end
    if (state == S_MUL) begin
      diff <= idx - rd_entry.lower;
    end
    if ((state == S_MUL) || (state == S_SCALE)) begin
      prod <= mul_p;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && (!out_valid || !out_stall)) begin
      address <= base_address + prod;
    end
  end

endmodule

@@ rtl/mda_checker.sv @@
// port-level checks for the multidim array address generator, with bind
module mda_checker
  import mda_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     op,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [WORD_W-1:0] address
);

  // an index transfer starts the multi-cycle sequence
  a_index_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && op == OP_INDEX) |=> in_stall)
    else $error("index transfer did not make the block busy");

  // a load transfer leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && op == OP_LOAD) |=> !in_stall)
    else $error("load transfer left the block busy");

  // a new result only comes out of a running sequence
  a_result_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a sequence in flight");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(address)))
    else $error("stalled result changed");

endmodule

bind multidim_array_address mda_checker u_mda_checker (.*);
